// ===== rtl/core/ple_pkg.sv =====
// Shared types, widths and codes of the positional list engine.
package ple_pkg;

	localparam int SLOT_W       = 6;
	localparam int OP_W         = 2;
	localparam int POS_W        = 6;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int LEN_W        = 6;
	localparam int CAPACITY_DEF = 32;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0]    len_t;

	localparam slot_t NULL_SLOT = 6'd63;

	localparam op_t OP_APPEND = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_DELETE = 2'd2;
	localparam op_t OP_DUMP   = 2'd3;

	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_NOT_CREATED = 3'd1;
	localparam status_t ST_BAD_POS     = 3'd2;
	localparam status_t ST_FULL        = 3'd3;
	localparam status_t ST_EMPTY       = 3'd4;

	typedef struct packed {
		logic  en;
		slot_t slot;
		data_t data;
	} ple_vwr_t;

	typedef struct packed {
		logic  en;
		slot_t slot;
		slot_t link;
	} ple_lwr_t;

	typedef struct packed {
		data_t value;
		slot_t next;
		slot_t prev;
	} ple_rd_t;

endpackage

// ===== rtl/core/ple_cmd_if.sv =====
// Command channel of the positional list engine.
interface ple_cmd_if;
	logic              valid;
	logic              ready;
	ple_pkg::op_t      operation;
	ple_pkg::pos_t     position;
	logic signed [ple_pkg::DATA_W-1:0] value;

	modport source(output valid, operation, position, value, input ready);
	modport sink(input valid, operation, position, value, output ready);
endinterface

// ===== rtl/core/ple_rsp_if.sv =====
// Response channel of the positional list engine.
interface ple_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [ple_pkg::DATA_W-1:0] element;
	ple_pkg::status_t  status;
	logic              last;
	ple_pkg::len_t     length;

	modport source(output valid, element, status, last, length, input ready);
	modport sink(input valid, element, status, last, length, output ready);
endinterface

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: command sequencer around the slot store.
//
// The block keeps an ordered list of signed 32-bit values in CAPACITY linked slots.
// Commands arrive on the cmd channel (operation, position, value); each transfer
// is one operation. Results leave on the rsp channel (element, status, last,
// length). Every command other than a dump of a non-empty list yields exactly one
// result with last set; a dump yields one result per element, head first.
// One command is worked on at a time; cmd.ready is high only while the block is
// idle. A rejected command goes straight to its result, and an append links its new
// slot after the tail without a walk. Insert and delete walk the next links from the
// head, reading each element passed through the walk and step states, before they
// link in or unlink their element. A dump reads and emits one element after another.
// The block returns to idle as its last result is loaded. The walk runs through the
// slot store's single read port, whose read is registered.
// Results are held in an output register; while the receiver stalls, the block can
// take one further command and then waits with its result, accepting nothing more.
// The asynchronous reset empties the list, frees all slots and clears the
// created flag; slot contents are not cleared.
module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ple_cmd_if.sink  cmd,
	ple_rsp_if.source rsp
);
	import ple_pkg::*;

	localparam int   AW      = $clog2(CAPACITY);
	localparam len_t CAP_LEN = len_t'(CAPACITY);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WALK  = 4'd1;
	localparam logic [3:0] S_WSTEP = 4'd2;
	localparam logic [3:0] S_LINK1 = 4'd3;
	localparam logic [3:0] S_LINK2 = 4'd4;
	localparam logic [3:0] S_DEL   = 4'd5;
	localparam logic [3:0] S_RESP  = 4'd6;
	localparam logic [3:0] S_DRD   = 4'd7;
	localparam logic [3:0] S_DEMIT = 4'd8;

	logic [3:0]            state_q;
	logic [CAPACITY-1:0]   free_q;
	slot_t                 head_q;
	slot_t                 tail_q;
	len_t                  count_q;
	logic                  created_q;
	logic                  rsp_valid_q;

	op_t                   op_q;
	data_t                 value_q;
	slot_t                 pred_q;
	slot_t                 cur_q;
	slot_t                 new_q;
	pos_t                  steps_q;
	len_t                  k_q;
	status_t               res_q;

	logic signed [DATA_W-1:0] element_q;
	status_t               status_q;
	logic                  last_q;
	len_t                  length_q;

	slot_t                 free_idx;
	logic                  cmd_fire;
	logic                  rsp_free;
	logic                  dump_last;
	logic                  emit_status;
	logic                  emit_dump;

	ple_vwr_t              val_wr;
	ple_lwr_t              nxt_wr;
	ple_lwr_t              prv_wr;
	ple_rd_t               rd;

	ple_store #(.CAPACITY(CAPACITY)) u_store (
		.clk    (clk),
		.rd_slot(cur_q),
		.val_wr (val_wr),
		.nxt_wr (nxt_wr),
		.prv_wr (prv_wr),
		.rd     (rd)
	);

	always_comb begin
		free_idx = NULL_SLOT;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = slot_t'(i);
			end
		end
	end

	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign rsp_free    = !rsp_valid_q || rsp.ready;
	assign dump_last   = (k_q == (count_q - len_t'(1)));
	assign emit_status = (state_q == S_RESP) && rsp_free;
	assign emit_dump   = (state_q == S_DEMIT) && rsp_free;

	always_comb begin
		val_wr = '{en: 1'b0, slot: new_q, data: value_q};
		nxt_wr = '{en: 1'b0, slot: new_q, link: cur_q};
		prv_wr = '{en: 1'b0, slot: new_q, link: pred_q};
		unique case (state_q)
			S_LINK1: begin
				val_wr.en = 1'b1;
				nxt_wr.en = 1'b1;
				prv_wr.en = 1'b1;
			end
			S_LINK2: begin
				nxt_wr = '{en: (pred_q != NULL_SLOT), slot: pred_q, link: new_q};
				prv_wr = '{en: (cur_q != NULL_SLOT), slot: cur_q, link: new_q};
			end
			S_DEL: begin
				nxt_wr = '{en: (rd.prev != NULL_SLOT), slot: rd.prev, link: rd.next};
				prv_wr = '{en: (rd.next != NULL_SLOT), slot: rd.next, link: rd.prev};
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= '1;
			head_q      <= NULL_SLOT;
			tail_q      <= NULL_SLOT;
			count_q     <= '0;
			created_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_status || emit_dump) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.operation)
							OP_APPEND: begin
								created_q <= 1'b1;
								state_q   <= (count_q >= CAP_LEN) ? S_RESP : S_LINK1;
							end
							OP_INSERT: begin
								if (!created_q || (cmd.position == '0)
										|| ({1'b0, cmd.position} > ({1'b0, count_q} + 7'd1))
										|| (count_q >= CAP_LEN)) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_WALK;
								end
							end
							OP_DELETE: begin
								if (!created_q || (count_q == '0) || (cmd.position == '0)
										|| (cmd.position > count_q)) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_WALK;
								end
							end
							OP_DUMP: begin
								state_q <= (count_q == '0) ? S_RESP : S_DRD;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (steps_q != '0) begin
						state_q <= S_WSTEP;
					end else if (op_q == OP_DELETE) begin
						state_q <= S_DEL;
					end else begin
						state_q <= S_LINK1;
					end
				end
				S_WSTEP: begin
					state_q <= S_WALK;
				end
				S_LINK1: begin
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					if (pred_q == NULL_SLOT) begin
						head_q <= new_q;
					end
					if (cur_q == NULL_SLOT) begin
						tail_q <= new_q;
					end
					free_q[new_q[AW-1:0]] <= 1'b0;
					count_q <= count_q + len_t'(1);
					state_q <= S_RESP;
				end
				S_DEL: begin
					if (rd.prev == NULL_SLOT) begin
						head_q <= rd.next;
					end
					if (rd.next == NULL_SLOT) begin
						tail_q <= rd.prev;
					end
					free_q[cur_q[AW-1:0]] <= 1'b1;
					count_q <= count_q - len_t'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DRD: begin
					state_q <= S_DEMIT;
				end
				S_DEMIT: begin
					if (rsp_free) begin
						state_q <= dump_last ? S_IDLE : S_DRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current command and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					op_q    <= cmd.operation;
					value_q <= cmd.value;
					new_q   <= free_idx;
					steps_q <= cmd.position - pos_t'(1);
					k_q     <= '0;
					res_q   <= ST_OK;
					if (cmd.operation == OP_APPEND) begin
						pred_q <= tail_q;
						cur_q  <= NULL_SLOT;
					end else begin
						pred_q <= NULL_SLOT;
						cur_q  <= head_q;
					end
					priority if (cmd.operation == OP_APPEND) begin
						if (count_q >= CAP_LEN) begin
							res_q <= ST_FULL;
						end
					end else if (cmd.operation == OP_DUMP) begin
						if (count_q == '0) begin
							res_q <= ST_EMPTY;
						end
					end else if (!created_q) begin
						res_q <= ST_NOT_CREATED;
					end else if (cmd.operation == OP_DELETE) begin
						if (count_q == '0) begin
							res_q <= ST_EMPTY;
						end else if ((cmd.position == '0) || (cmd.position > count_q)) begin
							res_q <= ST_BAD_POS;
						end
					end else begin
						if ((cmd.position == '0)
								|| ({1'b0, cmd.position} > ({1'b0, count_q} + 7'd1))) begin
							res_q <= ST_BAD_POS;
						end else if (count_q >= CAP_LEN) begin
							res_q <= ST_FULL;
						end
					end
				end
			end
			S_WSTEP: begin
				pred_q  <= cur_q;
				cur_q   <= rd.next;
				steps_q <= steps_q - pos_t'(1);
			end
			S_DEMIT: begin
				if (rsp_free) begin
					cur_q <= rd.next;
					k_q   <= k_q + len_t'(1);
				end
			end
			default: begin
			end
		endcase
		if (emit_status) begin
			element_q <= '0;
			status_q  <= res_q;
			last_q    <= 1'b1;
			length_q  <= count_q;
		end else if (emit_dump) begin
			element_q <= rd.value;
			status_q  <= ST_OK;
			last_q    <= dump_last;
			length_q  <= count_q;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.element = element_q;
	assign rsp.status  = status_q;
	assign rsp.last    = last_q;
	assign rsp.length  = length_q;

endmodule

// ===== rtl/core/ple_store.sv =====
// Slot store: value, next-link and prev-link memories with registered read.
module ple_store #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  ple_pkg::slot_t    rd_slot,
	input  ple_pkg::ple_vwr_t val_wr,
	input  ple_pkg::ple_lwr_t nxt_wr,
	input  ple_pkg::ple_lwr_t prv_wr,
	output ple_pkg::ple_rd_t  rd
);
	import ple_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	data_t val_mem [CAPACITY];
	slot_t nxt_mem [CAPACITY];
	slot_t prv_mem [CAPACITY];

	always_ff @(posedge clk) begin
		rd.value <= val_mem[rd_slot[AW-1:0]];
		rd.next  <= nxt_mem[rd_slot[AW-1:0]];
		rd.prev  <= prv_mem[rd_slot[AW-1:0]];
		if (val_wr.en) begin
			val_mem[val_wr.slot[AW-1:0]] <= val_wr.data;
		end
		if (nxt_wr.en) begin
			nxt_mem[nxt_wr.slot[AW-1:0]] <= nxt_wr.link;
		end
		if (prv_wr.en) begin
			prv_mem[prv_wr.slot[AW-1:0]] <= prv_wr.link;
		end
	end

endmodule
